[rtl/i2cbs_pkg.sv]
`timescale 1ns / 1ps

package i2cbs_pkg;

  localparam int unsigned HOLD_W = 16;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd250;
  localparam int unsigned PC_W = 5;
  localparam int unsigned BIT_W = 3;

  localparam logic [2:0] CMD_START     = 3'd0;
  localparam logic [2:0] CMD_STOP      = 3'd1;
  localparam logic [2:0] CMD_SEND_BYTE = 3'd2;
  localparam logic [2:0] CMD_RECV_BYTE = 3'd3;
  localparam logic [2:0] CMD_SEND_ACK  = 3'd4;
  localparam logic [2:0] CMD_RECV_ACK  = 3'd5;

  localparam logic [PC_W-1:0] A_START     = 5'd0;
  localparam logic [PC_W-1:0] A_STOP      = 5'd4;
  localparam logic [PC_W-1:0] A_SEND_BYTE = 5'd8;
  localparam logic [PC_W-1:0] A_RECV_BYTE = 5'd11;
  localparam logic [PC_W-1:0] A_RECV_LOOP = 5'd12;
  localparam logic [PC_W-1:0] A_SEND_ACK  = 5'd15;
  localparam logic [PC_W-1:0] A_RECV_ACK  = 5'd18;

  typedef enum logic [1:0] {
    LINE_SCL,
    LINE_SDA,
    LINE_SAMPLE
  } line_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_ONE,
    SRC_TX,
    SRC_ACK
  } src_t;

  typedef struct packed {
    line_t           line;
    src_t            src;
    logic            clr_shift;
    logic            loop;
    logic [PC_W-1:0] target;
    logic            fin;
    logic            show_rx;
    logic            show_ack;
  } cw_t;

  typedef struct packed {
    logic             load;
    logic             exec;
    cw_t              cw;
    logic [BIT_W-1:0] bit_idx;
    logic             fin;
  } seq_ctl_t;

  function automatic cw_t mk(line_t line, src_t src, logic clr, logic loop,
                             logic [PC_W-1:0] target, logic fin, logic rx, logic ack);
    cw_t w;
    w.line      = line;
    w.src       = src;
    w.clr_shift = clr;
    w.loop      = loop;
    w.target    = target;
    w.fin       = fin;
    w.show_rx   = rx;
    w.show_ack  = ack;
    return w;
  endfunction

  function automatic cw_t rom_word(logic [PC_W-1:0] pc);
    cw_t w;
    w = mk(LINE_SCL, SRC_ZERO, 1'b0, 1'b0, A_START, 1'b1, 1'b0, 1'b0);
    unique case (pc)
      5'd0:  w = mk(LINE_SDA, SRC_ONE, 1'b0, 1'b0, A_START, 1'b0, 1'b0, 1'b0);
      5'd1:  w = mk(LINE_SCL, SRC_ONE, 1'b0, 1'b0, A_START, 1'b0, 1'b0, 1'b0);
      5'd2:  w = mk(LINE_SDA, SRC_ZERO, 1'b0, 1'b0, A_START, 1'b0, 1'b0, 1'b0);
      5'd3:  w = mk(LINE_SCL, SRC_ZERO, 1'b0, 1'b0, A_START, 1'b1, 1'b0, 1'b0);
      5'd4:  w = mk(LINE_SDA, SRC_ZERO, 1'b0, 1'b0, A_START, 1'b0, 1'b0, 1'b0);
      5'd5:  w = mk(LINE_SCL, SRC_ZERO, 1'b0, 1'b0, A_START, 1'b0, 1'b0, 1'b0);
      5'd6:  w = mk(LINE_SCL, SRC_ONE, 1'b0, 1'b0, A_START, 1'b0, 1'b0, 1'b0);
      5'd7:  w = mk(LINE_SDA, SRC_ONE, 1'b0, 1'b0, A_START, 1'b1, 1'b0, 1'b0);
      5'd8:  w = mk(LINE_SDA, SRC_TX, 1'b0, 1'b0, A_START, 1'b0, 1'b0, 1'b0);
      5'd9:  w = mk(LINE_SCL, SRC_ONE, 1'b0, 1'b0, A_START, 1'b0, 1'b0, 1'b0);
      5'd10: w = mk(LINE_SCL, SRC_ZERO, 1'b0, 1'b1, A_SEND_BYTE, 1'b0, 1'b0, 1'b0);
      5'd11: w = mk(LINE_SDA, SRC_ONE, 1'b1, 1'b0, A_START, 1'b0, 1'b0, 1'b0);
      5'd12: w = mk(LINE_SCL, SRC_ONE, 1'b0, 1'b0, A_START, 1'b0, 1'b0, 1'b0);
      5'd13: w = mk(LINE_SAMPLE, SRC_ZERO, 1'b0, 1'b0, A_START, 1'b0, 1'b0, 1'b0);
      5'd14: w = mk(LINE_SCL, SRC_ZERO, 1'b0, 1'b1, A_RECV_LOOP, 1'b0, 1'b1, 1'b0);
      5'd15: w = mk(LINE_SDA, SRC_ACK, 1'b0, 1'b0, A_START, 1'b0, 1'b0, 1'b0);
      5'd16: w = mk(LINE_SCL, SRC_ONE, 1'b0, 1'b0, A_START, 1'b0, 1'b0, 1'b0);
      5'd17: w = mk(LINE_SCL, SRC_ZERO, 1'b0, 1'b0, A_START, 1'b1, 1'b0, 1'b0);
      5'd18: w = mk(LINE_SDA, SRC_ONE, 1'b0, 1'b0, A_START, 1'b0, 1'b0, 1'b0);
      5'd19: w = mk(LINE_SCL, SRC_ONE, 1'b0, 1'b0, A_START, 1'b0, 1'b0, 1'b0);
      5'd20: w = mk(LINE_SAMPLE, SRC_ZERO, 1'b0, 1'b0, A_START, 1'b0, 1'b0, 1'b0);
      5'd21: w = mk(LINE_SCL, SRC_ZERO, 1'b0, 1'b0, A_START, 1'b1, 1'b0, 1'b1);
      default: w = mk(LINE_SCL, SRC_ZERO, 1'b0, 1'b0, A_START, 1'b1, 1'b0, 1'b0);
    endcase
    return w;
  endfunction

  function automatic logic [PC_W-1:0] entry_pc(logic [2:0] cmd);
    logic [PC_W-1:0] pc;
    pc = A_START;
    unique case (cmd)
      CMD_START:     pc = A_START;
      CMD_STOP:      pc = A_STOP;
      CMD_SEND_BYTE: pc = A_SEND_BYTE;
      CMD_RECV_BYTE: pc = A_RECV_BYTE;
      CMD_SEND_ACK:  pc = A_SEND_ACK;
      CMD_RECV_ACK:  pc = A_RECV_ACK;
      default:       pc = A_START;
    endcase
    return pc;
  endfunction

endpackage

[rtl/i2cbs_in_if.sv]
`timescale 1ns / 1ps

interface i2cbs_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] tx_byte;
  logic       ack_bit;
  logic [7:0] bus_bits;
  logic       bus_ack;

  modport source (output valid, cmd, tx_byte, ack_bit, bus_bits, bus_ack, input ready);
  modport sink (input valid, cmd, tx_byte, ack_bit, bus_bits, bus_ack, output ready);
endinterface

[rtl/i2cbs_out_if.sv]
`timescale 1ns / 1ps

interface i2cbs_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sample_step;
  logic [7:0] rx_byte;
  logic       ack_seen;
  logic       last;

  modport source (output valid, scl_level, sda_level, sample_step, rx_byte, ack_seen, last,
                  input ready);
  modport sink (input valid, scl_level, sda_level, sample_step, rx_byte, ack_seen, last,
                output ready);
endinterface

[rtl/i2c_master_bit_sequencer.sv]
`timescale 1ns / 1ps
// Channel   Direction  Beat contents
// in_chan   sink       cmd, tx_byte, ack_bit, bus_bits, bus_ack (one command)
// out_chan  source     scl_level, sda_level, sample_step, rx_byte, ack_seen, last (one step)
// cfg       write      hold_ticks, 16 bit, zero is taken as one
//
// Every line step waits on the step timer, loaded from hold_ticks, before its beat is issued,
// and a command runs its step count (3 to 25) of such steps.
// Commands are taken one at a time; the next is accepted once the final step is issued.
// A stalled result holds the step timer at zero until the output register frees.
// Synchronous reset releases both lines, clears the shift register and sets hold to 250.

module i2c_master_bit_sequencer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [i2cbs_pkg::HOLD_W-1:0] cfg_wr_data,
  i2cbs_in_if.sink                     in_chan,
  i2cbs_out_if.source                  out_chan
);

  logic [i2cbs_pkg::HOLD_W-1:0] hold_r, hold_nxt;
  i2cbs_pkg::seq_ctl_t          seq_ctl;
  logic                         out_free;

  always_comb begin
    hold_nxt = hold_r;
    if (cfg_wr_en) begin
      hold_nxt = (cfg_wr_data == '0) ? {{(i2cbs_pkg::HOLD_W-1){1'b0}}, 1'b1} : cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= i2cbs_pkg::HOLD_RESET;
    end else begin
      hold_r <= hold_nxt;
    end
  end

  i2cbs_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_cmd     (in_chan.cmd),
    .in_ready   (in_chan.ready),
    .hold_ticks (hold_r),
    .out_free   (out_free),
    .ctl        (seq_ctl)
  );

  i2cbs_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tx_byte  (in_chan.tx_byte),
    .in_ack_bit  (in_chan.ack_bit),
    .in_bus_bits (in_chan.bus_bits),
    .in_bus_ack  (in_chan.bus_ack),
    .ctl         (seq_ctl),
    .out_free    (out_free),
    .out_chan    (out_chan)
  );

  a_legal_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && (in_chan.cmd <= i2cbs_pkg::CMD_RECV_ACK))
    |=> !in_chan.ready)
    else $error("legal command did not start the sequencer");

  a_fin_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_ctl.exec && seq_ctl.fin) |=> (in_chan.ready && out_chan.valid && out_chan.last))
    else $error("final step did not end the command");

  a_sample_scl_high: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.sample_step) |-> out_chan.scl_level)
    else $error("sample step issued with SCL low");

  a_rx_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && ((out_chan.rx_byte != 8'd0) || out_chan.ack_seen)) |-> out_chan.last)
    else $error("received data shown on a step that is not the last");

endmodule

[rtl/i2cbs_seq.sv]
`timescale 1ns / 1ps

module i2cbs_seq (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [2:0]                       in_cmd,
  output logic                             in_ready,
  input  logic [i2cbs_pkg::HOLD_W-1:0]     hold_ticks,
  input  logic                             out_free,
  output i2cbs_pkg::seq_ctl_t              ctl
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t                         state_r, state_nxt;
  logic [i2cbs_pkg::PC_W-1:0]     pc_r, pc_nxt;
  logic [i2cbs_pkg::BIT_W-1:0]    bit_r, bit_nxt;
  logic [i2cbs_pkg::HOLD_W-1:0]   cnt_r, cnt_nxt;
  i2cbs_pkg::cw_t                 cw;
  logic                           accept;
  logic                           exec;
  logic                           loop_back;
  logic                           fin;

  assign cw        = i2cbs_pkg::rom_word(pc_r);
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign exec      = (state_r == S_RUN) && (cnt_r == '0) && out_free;
  assign loop_back = cw.loop && (bit_r != {i2cbs_pkg::BIT_W{1'b1}});
  assign fin       = cw.fin || (cw.loop && !loop_back);

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    bit_nxt   = bit_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_cmd <= i2cbs_pkg::CMD_RECV_ACK)) begin
          state_nxt = S_RUN;
          pc_nxt    = i2cbs_pkg::entry_pc(in_cmd);
          bit_nxt   = '0;
          cnt_nxt   = hold_ticks - 1'b1;
        end
      end
      S_RUN: begin
        if (exec) begin
          cnt_nxt = hold_ticks - 1'b1;
          if (fin) begin
            state_nxt = S_IDLE;
          end else if (loop_back) begin
            pc_nxt  = cw.target;
            bit_nxt = bit_r + 1'b1;
          end else begin
            pc_nxt = pc_r + 1'b1;
          end
        end else if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
      bit_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      bit_r   <= bit_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign ctl.load    = accept;
  assign ctl.exec    = exec;
  assign ctl.cw      = cw;
  assign ctl.bit_idx = bit_r;
  assign ctl.fin     = fin;

endmodule

[rtl/i2cbs_datapath.sv]
`timescale 1ns / 1ps

module i2cbs_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_tx_byte,
  input  logic                in_ack_bit,
  input  logic [7:0]          in_bus_bits,
  input  logic                in_bus_ack,
  input  i2cbs_pkg::seq_ctl_t ctl,
  output logic                out_free,
  i2cbs_out_if.source         out_chan
);

  logic [7:0] tx_r, bits_r;
  logic       ackb_r, back_r;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       val;
  logic       ov_r, ov_nxt;
  logic       o_scl_r, o_sda_r, o_sample_r, o_ack_r, o_last_r;
  logic [7:0] o_rx_r;

  assign out_free = !ov_r || out_chan.ready;

  always_comb begin
    val = 1'b0;
    case (ctl.cw.src)
      i2cbs_pkg::SRC_ZERO: val = 1'b0;
      i2cbs_pkg::SRC_ONE:  val = 1'b1;
      i2cbs_pkg::SRC_TX:   val = tx_r[~ctl.bit_idx];
      i2cbs_pkg::SRC_ACK:  val = ackb_r;
      default:             val = 1'b0;
    endcase
  end

  always_comb begin
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    shift_nxt = shift_r;
    if (ctl.exec) begin
      case (ctl.cw.line)
        i2cbs_pkg::LINE_SCL:    scl_nxt = val;
        i2cbs_pkg::LINE_SDA:    sda_nxt = val;
        i2cbs_pkg::LINE_SAMPLE: shift_nxt = {shift_r[6:0], bits_r[~ctl.bit_idx]};
        default:                scl_nxt = scl_r;
      endcase
      if (ctl.cw.clr_shift) begin
        shift_nxt = '0;
      end
    end
    ov_nxt = ctl.exec ? 1'b1 : (out_chan.ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      shift_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      shift_r <= shift_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      tx_r   <= in_tx_byte;
      ackb_r <= in_ack_bit;
      bits_r <= in_bus_bits;
      back_r <= in_bus_ack;
    end
    if (ctl.exec) begin
      o_scl_r    <= scl_nxt;
      o_sda_r    <= sda_nxt;
      o_sample_r <= (ctl.cw.line == i2cbs_pkg::LINE_SAMPLE);
      o_rx_r     <= (ctl.cw.show_rx && ctl.fin) ? shift_r : 8'd0;
      o_ack_r    <= ctl.cw.show_ack ? back_r : 1'b0;
      o_last_r   <= ctl.fin;
    end
  end

  assign out_chan.valid       = ov_r;
  assign out_chan.scl_level   = o_scl_r;
  assign out_chan.sda_level   = o_sda_r;
  assign out_chan.sample_step = o_sample_r;
  assign out_chan.rx_byte     = o_rx_r;
  assign out_chan.ack_seen    = o_ack_r;
  assign out_chan.last        = o_last_r;

endmodule
